// ----- design/sub_cpu_bus_arbiter_bank_mapper_assert.svh -----
// Assertion macros shared by the checker.
`ifndef SUB_CPU_BUS_ARBITER_BANK_MAPPER_ASSERT_SVH
`define SUB_CPU_BUS_ARBITER_BANK_MAPPER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SCBAM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scbam assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SCBAM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scbam assertion failed");

`endif

// ----- design/scbam_pkg.sv -----
`timescale 1ns / 1ps
package scbam_pkg;

  typedef enum logic [2:0] {
    FUNC_ACK_READ    = 3'd0,
    FUNC_REQ_WRITE   = 3'd1,
    FUNC_RESET_WRITE = 3'd2,
    FUNC_BANK_BIT    = 3'd3,
    FUNC_MAPPER_WR   = 3'd4,
    FUNC_LOOKUP      = 3'd5,
    FUNC_BLOCK_RESET = 3'd6
  } func_e;

  localparam int unsigned DeadlineW = 19;
  localparam logic [DeadlineW-1:0] DeadlineOffset = 19'd16;
  localparam logic [21:0] BootMask = 22'h0007FF;
  localparam logic [2:0] MapperRamCtrl = 3'd0;

  typedef struct packed {
    logic [2:0]  func;
    logic        control_bit;
    logic [2:0]  mapper_register;
    logic [5:0]  mapper_value;
    logic [17:0] cpu_cycle;
    logic [21:0] lookup_address;
  } scbam_req_t;

  typedef struct packed {
    logic        bus_ack;
    logic        bus_requested;
    logic        sub_cpu_running;
    logic [23:0] bank_base;
    logic        save_ram_enabled;
    logic        save_ram_writable;
    logic [24:0] mapped_address;
    logic        from_boot_rom;
  } scbam_rsp_t;

  typedef struct packed {
    logic update;  // apply request to state, capture cycle and address
    logic load;    // compute result into output register
  } scbam_cmd_t;

endpackage

// ----- design/scbam_ctrl.sv -----
`timescale 1ns / 1ps
module scbam_ctrl
  import scbam_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output scbam_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    in_stall_o  = 1'b0;
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_EXEC: begin
        in_stall_o = !out_free;
        if (out_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    accept       = in_valid_i && !in_stall_o;
    cmd_o.update = accept;
    if (accept) begin
      state_d = ST_EXEC;
    end else if (state_q != ST_EXEC || out_free) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/scbam_datapath.sv -----
`timescale 1ns / 1ps
module scbam_datapath
  import scbam_pkg::*;
#(
  parameter int unsigned BANK_COUNT       = 8,
  parameter int unsigned BANK_SHIFT       = 19,
  parameter int unsigned BANK_NUMBER_BITS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  scbam_cmd_t cmd_i,
  input  scbam_req_t req_i,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  output scbam_rsp_t rsp_o
);

  localparam logic [31:0] LowMask = (32'd1 << BANK_SHIFT) - 32'd1;

  logic                        boot_cfg_q;
  logic                        request_q, request_d;
  logic                        running_q, running_d;
  logic                        ack_q, ack_d;
  logic [DeadlineW-1:0]        deadline_q, deadline_d;
  logic                        prev_ack_q, prev_ack_d;
  logic [8:0]                  window_q, window_d;
  logic [BANK_NUMBER_BITS-1:0] bank_q [BANK_COUNT];
  logic [BANK_NUMBER_BITS-1:0] bank_d [BANK_COUNT];
  logic                        boot_sel_q, boot_sel_d;
  logic                        ram_on_q, ram_on_d;
  logic                        ram_wr_q, ram_wr_d;
  logic [17:0]                 cycle_q;
  logic [21:0]                 addr_q;
  scbam_rsp_t                  rsp_q;

  logic [21:0]                 slot;
  logic                        slot_ok;
  logic [BANK_NUMBER_BITS-1:0] slot_bank;
  logic [31:0]                 cart_addr;
  logic                        ack_val;

  // State update for one request
  always_comb begin
    request_d  = request_q;
    running_d  = running_q;
    ack_d      = ack_q;
    deadline_d = deadline_q;
    prev_ack_d = prev_ack_q;
    window_d   = window_q;
    bank_d     = bank_q;
    boot_sel_d = boot_sel_q;
    ram_on_d   = ram_on_q;
    ram_wr_d   = ram_wr_q;
    case (req_i.func)
      FUNC_REQ_WRITE: begin
        deadline_d = DeadlineW'(req_i.cpu_cycle) + DeadlineOffset;
        prev_ack_d = ack_q;
        request_d  = req_i.control_bit;
        ack_d      = !(req_i.control_bit && running_q);
      end
      FUNC_RESET_WRITE: begin
        if (!req_i.control_bit) begin
          deadline_d = '0;
          prev_ack_d = 1'b1;
        end
        running_d = req_i.control_bit;
        ack_d     = !(request_q && req_i.control_bit);
      end
      FUNC_BANK_BIT: begin
        window_d = {req_i.control_bit, window_q[8:1]};
      end
      FUNC_MAPPER_WR: begin
        if (req_i.mapper_register == MapperRamCtrl) begin
          ram_on_d = req_i.mapper_value[0];
          ram_wr_d = !req_i.mapper_value[1];
        end else begin
          for (int i = 0; i < BANK_COUNT; i++) begin
            if (32'(req_i.mapper_register) == i) begin
              bank_d[i] = BANK_NUMBER_BITS'(req_i.mapper_value);
            end
          end
        end
      end
      FUNC_BLOCK_RESET: begin
        request_d  = 1'b0;
        running_d  = 1'b0;
        ack_d      = 1'b1;
        deadline_d = '0;
        prev_ack_d = 1'b1;
        window_d   = '0;
        if (req_i.control_bit) begin
          for (int i = 0; i < BANK_COUNT; i++) begin
            bank_d[i] = BANK_NUMBER_BITS'(i);
          end
          boot_sel_d = boot_cfg_q;
        end
      end
      default: begin
        request_d = request_q;
      end
    endcase
  end

  // Result from updated state
  assign slot    = addr_q >> BANK_SHIFT;
  assign slot_ok = 32'(slot) < BANK_COUNT;

  always_comb begin
    slot_bank = '0;
    for (int i = 0; i < BANK_COUNT; i++) begin
      if (32'(slot) == i) begin
        slot_bank = bank_q[i];
      end
    end
  end

  assign cart_addr = (32'(slot_bank) << BANK_SHIFT) | (32'(addr_q) & LowMask);
  assign ack_val   = ack_q || ((32'(cycle_q) <= 32'(deadline_q)) && prev_ack_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_cfg_q <= 1'b0;
      request_q  <= 1'b0;
      running_q  <= 1'b0;
      ack_q      <= 1'b1;
      deadline_q <= '0;
      prev_ack_q <= 1'b1;
      window_q   <= '0;
      for (int i = 0; i < BANK_COUNT; i++) begin
        bank_q[i] <= BANK_NUMBER_BITS'(i);
      end
      boot_sel_q <= 1'b0;
      ram_on_q   <= 1'b0;
      ram_wr_q   <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        boot_cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.update) begin
        request_q  <= request_d;
        running_q  <= running_d;
        ack_q      <= ack_d;
        deadline_q <= deadline_d;
        prev_ack_q <= prev_ack_d;
        window_q   <= window_d;
        bank_q     <= bank_d;
        boot_sel_q <= boot_sel_d;
        ram_on_q   <= ram_on_d;
        ram_wr_q   <= ram_wr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      cycle_q <= req_i.cpu_cycle;
      addr_q  <= req_i.lookup_address;
    end
    if (cmd_i.load) begin
      rsp_q.bus_ack           <= ack_val;
      rsp_q.bus_requested     <= request_q;
      rsp_q.sub_cpu_running   <= running_q;
      rsp_q.bank_base         <= {window_q, 15'b0};
      rsp_q.save_ram_enabled  <= ram_on_q;
      rsp_q.save_ram_writable <= ram_wr_q;
      if (!slot_ok) begin
        rsp_q.mapped_address <= '0;
        rsp_q.from_boot_rom  <= 1'b0;
      end else if (slot == '0 && boot_sel_q) begin
        rsp_q.mapped_address <= 25'(addr_q & BootMask);
        rsp_q.from_boot_rom  <= 1'b1;
      end else begin
        rsp_q.mapped_address <= cart_addr[24:0];
        rsp_q.from_boot_rom  <= 1'b0;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ----- design/sub_cpu_bus_arbiter_bank_mapper.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// in        in   in_valid_i/in_stall_o  in_req_i  (scbam_req_t)
// out       out  out_valid_o/out_stall_i out_rsp_o (scbam_rsp_t)
// cfg       in   cfg_we_i               cfg_wdata_i (boot ROM select)
//
// A request updates the state at its accepting edge; the result is then registered
// once the result register is free; a new request is taken every cycle unless it stalls.
// The result register is the only holding stage: while it is stalled and full,
// a request in flight waits and in_stall_o is high.
// Reset (rst_ni low, async) restores the flags, window and identity bank table.
module sub_cpu_bus_arbiter_bank_mapper
  import scbam_pkg::*;
#(
  parameter int unsigned BANK_COUNT       = 8,
  parameter int unsigned BANK_SHIFT       = 19,
  parameter int unsigned BANK_NUMBER_BITS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  scbam_req_t in_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output scbam_rsp_t out_rsp_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  scbam_cmd_t cmd;

  scbam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  scbam_datapath #(
    .BANK_COUNT       (BANK_COUNT),
    .BANK_SHIFT       (BANK_SHIFT),
    .BANK_NUMBER_BITS (BANK_NUMBER_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (out_rsp_o)
  );

endmodule

// ----- design/scbam_checker.sv -----
`timescale 1ns / 1ps
`include "sub_cpu_bus_arbiter_bank_mapper_assert.svh"
module scbam_checker
  import scbam_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input scbam_rsp_t out_rsp_o
);

  `SCBAM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `SCBAM_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_rsp_o))
  `SCBAM_ASSERT_NEXT(a_accept_gives_result, in_valid_i && !in_stall_o, ##1 out_valid_o)
  `SCBAM_ASSERT_IMPL(a_grant_needs_req, out_valid_o && !out_rsp_o.bus_ack, out_rsp_o.bus_requested && out_rsp_o.sub_cpu_running)
  `SCBAM_ASSERT_IMPL(a_boot_wraps, out_valid_o && out_rsp_o.from_boot_rom, out_rsp_o.mapped_address[24:11] == '0)

endmodule

bind sub_cpu_bus_arbiter_bank_mapper scbam_checker u_checker (.*);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import scbam_pkg::*;

  localparam int BankCount = 8;
  localparam int BankShift = 19;
  localparam int BankBits = 6;
  localparam logic [2:0] FuncSpare = 3'd7;
  localparam int HoldCycles = 300;
  localparam int QuietLimit = 4000;
  localparam int ReportCap = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  scbam_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  scbam_rsp_t out_rsp_o;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  sub_cpu_bus_arbiter_bank_mapper #(
    .BANK_COUNT(BankCount),
    .BANK_SHIFT(BankShift),
    .BANK_NUMBER_BITS(BankBits)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i(in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o(out_rsp_o),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predicted controller state
  logic boot_cfg;
  logic req_line, run_line, ack_line, last_ack;
  logic [DeadlineW-1:0] grant_deadline;
  logic [8:0] window_reg;
  logic [BankBits-1:0] bank_sel [BankCount];
  logic boot_map_on, sram_on, sram_wr_ok;

  scbam_req_t pending [$];
  scbam_rsp_t status_due [$];
  scbam_rsp_t due;
  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit pause_send = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;
  logic in_taken = 1'b0;

  function automatic void clear_bus_state(input bit hard);
    if (hard) begin
      for (int i = 0; i < BankCount; i++) bank_sel[i] = BankBits'(i);
      boot_map_on = boot_cfg;
    end
    req_line = 1'b0;
    run_line = 1'b0;
    ack_line = 1'b1;
    grant_deadline = '0;
    last_ack = 1'b1;
    window_reg = '0;
  endfunction

  function automatic scbam_rsp_t advance_bus_state(input scbam_req_t r);
    scbam_rsp_t s;
    int slot;
    s = '0;
    case (r.func)
      FUNC_REQ_WRITE: begin
        grant_deadline = {1'b0, r.cpu_cycle} + DeadlineOffset;
        last_ack = ack_line;
        req_line = r.control_bit;
        ack_line = ~(req_line & run_line);
      end
      FUNC_RESET_WRITE: begin
        if (!r.control_bit) begin
          grant_deadline = '0;
          last_ack = 1'b1;
        end
        run_line = r.control_bit;
        ack_line = ~(req_line & run_line);
      end
      FUNC_BANK_BIT: window_reg = {r.control_bit, window_reg[8:1]};
      FUNC_MAPPER_WR: begin
        if (r.mapper_register == MapperRamCtrl) begin
          sram_on = r.mapper_value[0];
          sram_wr_ok = ~r.mapper_value[1];
        end else if (int'(r.mapper_register) < BankCount) begin
          bank_sel[r.mapper_register] = r.mapper_value[BankBits-1:0];
        end
      end
      FUNC_BLOCK_RESET: clear_bus_state(r.control_bit);
      default: ;
    endcase
    if (ack_line) s.bus_ack = 1'b1;
    else s.bus_ack = ({1'b0, r.cpu_cycle} > grant_deadline) ? 1'b0 : last_ack;
    s.bus_requested = req_line;
    s.sub_cpu_running = run_line;
    s.bank_base = {window_reg, 15'd0};
    s.save_ram_enabled = sram_on;
    s.save_ram_writable = sram_wr_ok;
    slot = int'(r.lookup_address >> BankShift);
    if (slot < BankCount) begin
      if (slot == 0 && boot_map_on) begin
        s.mapped_address = 25'(r.lookup_address & BootMask);
        s.from_boot_rom = 1'b1;
      end else begin
        s.mapped_address = {bank_sel[slot], r.lookup_address[BankShift-1:0]};
      end
    end
    return s;
  endfunction

  function automatic bit status_differs(input scbam_rsp_t a, input scbam_rsp_t b);
    return (a.bus_ack !== b.bus_ack) || (a.bus_requested !== b.bus_requested) ||
           (a.sub_cpu_running !== b.sub_cpu_running) || (a.bank_base !== b.bank_base) ||
           (a.save_ram_enabled !== b.save_ram_enabled) ||
           (a.save_ram_writable !== b.save_ram_writable) ||
           (a.mapped_address !== b.mapped_address) ||
           (a.from_boot_rom !== b.from_boot_rom);
  endfunction

  task automatic note_mismatch(input bit have_exp, input scbam_rsp_t e, input scbam_rsp_t g);
    mismatch_count++;
    if (mismatch_count <= ReportCap) begin
      if (have_exp)
        $display("%0t exp ack=%b req=%b run=%b base=%h ram=%b%b map=%h boot=%b", $realtime,
                 e.bus_ack, e.bus_requested, e.sub_cpu_running, e.bank_base,
                 e.save_ram_enabled, e.save_ram_writable, e.mapped_address, e.from_boot_rom);
      else
        $display("%0t unexpected result", $realtime);
      $display("%0t got ack=%b req=%b run=%b base=%h ram=%b%b map=%h boot=%b", $realtime,
               g.bus_ack, g.bus_requested, g.sub_cpu_running, g.bank_base,
               g.save_ram_enabled, g.save_ram_writable, g.mapped_address, g.from_boot_rom);
    end
  endtask

  // monitor: accepts on rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      if (cfg_we_i) boot_cfg = cfg_wdata_i;
      if (out_valid_o && !out_stall_i) begin
        if (status_due.size() == 0) begin
          note_mismatch(1'b0, '0, out_rsp_o);
        end else begin
          due = status_due.pop_front();
          if (status_differs(due, out_rsp_o)) note_mismatch(1'b1, due, out_rsp_o);
        end
      end
      if (in_valid_i && !in_stall_o) status_due.push_back(advance_bus_state(in_req_i));
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (pending.size() != 0 && !pause_send && $urandom_range(99) >= idle_pct) begin
        in_req_i <= pending.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with a counted long hold-off on demand
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      out_stall_i <= 1'b1;
      if (hold_cnt == HoldCycles - 1) hold_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      hold_cnt <= 0;
      if (!hold_req) hold_done <= 1'b0;
    end
  end

  function automatic scbam_req_t mk(input logic [2:0] f, input logic b, input logic [2:0] rg,
                                    input logic [5:0] v, input logic [17:0] c,
                                    input logic [21:0] a);
    scbam_req_t r;
    r.func = f;
    r.control_bit = b;
    r.mapper_register = rg;
    r.mapper_value = v;
    r.cpu_cycle = c;
    r.lookup_address = a;
    return r;
  endfunction

  function automatic logic [17:0] rand_cycle();
    if ($urandom_range(3) == 0) return 18'h3FFFF - 18'($urandom_range(40));
    return 18'($urandom);
  endfunction

  function automatic scbam_req_t noise_access();
    return mk(3'($urandom_range(7)), 1'($urandom), 3'($urandom), 6'($urandom),
              rand_cycle(), 22'($urandom));
  endfunction

  task automatic push_op(input logic [2:0] f, input logic b);
    scbam_req_t a;
    a = noise_access();
    a.func = f;
    a.control_bit = b;
    pending.push_back(a);
  endtask

  task automatic queue_random(input int n);
    int made, pick, k, cnt;
    logic [17:0] t;
    scbam_req_t a;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        t = rand_cycle();
        if ($urandom_range(1)) begin
          push_op(FUNC_RESET_WRITE, 1'b1);
          made++;
        end
        a = noise_access();
        a.func = FUNC_REQ_WRITE;
        a.control_bit = 1'b1;
        a.cpu_cycle = t;
        pending.push_back(a);
        cnt = $urandom_range(1, 4);
        for (k = 0; k < cnt; k++) begin
          a = noise_access();
          a.func = FUNC_ACK_READ;
          a.cpu_cycle = t + 18'($urandom_range(32));
          pending.push_back(a);
        end
        push_op($urandom_range(1) ? FUNC_REQ_WRITE : FUNC_RESET_WRITE, 1'($urandom_range(3) == 0));
        made += cnt + 2;
      end else if (pick < 45) begin
        for (k = 0; k < 9; k++) push_op(FUNC_BANK_BIT, 1'($urandom));
        made += 9;
      end else if (pick < 70) begin
        cnt = $urandom_range(1, 3);
        for (k = 0; k < cnt; k++) push_op(FUNC_MAPPER_WR, 1'($urandom));
        made += cnt;
        cnt = $urandom_range(1, 3);
        for (k = 0; k < cnt; k++) push_op(FUNC_LOOKUP, 1'($urandom));
        made += cnt;
      end else if (pick < 78) begin
        push_op(FUNC_BLOCK_RESET, 1'($urandom));
        a = noise_access();
        a.func = FUNC_LOOKUP;
        a.lookup_address[21:BankShift] = '0;
        pending.push_back(a);
        made += 2;
      end else begin
        pending.push_back(noise_access());
        made++;
      end
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending.size() != 0 || in_valid_i || status_due.size() != 0);
  endtask

  task automatic start_phase(input logic boot, input int s_idle, input int r_stall);
    wait_quiet();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= boot;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    idle_pct = s_idle;
    stall_pct = r_stall;
  endtask

  initial begin
    boot_cfg = 1'b0;
    clear_bus_state(1'b1);
    boot_map_on = 1'b0;
    sram_on = 1'b0;
    sram_wr_ok = 1'b1;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    start_phase(1'b1, 0, 0);
    pending.push_back(mk(FUNC_ACK_READ, 1'b0, 3'd0, 6'd0, 18'd0, 22'd0));
    pending.push_back(mk(FUNC_LOOKUP, 1'b1, 3'd7, 6'd63, 18'h3FFFF, 22'h3FFFFF));
    pending.push_back(mk(FUNC_LOOKUP, 1'b0, 3'd0, 6'd0, 18'd0, 22'h07FFFF));
    pending.push_back(mk(FUNC_MAPPER_WR, 1'b0, MapperRamCtrl, 6'd3, 18'd5, 22'h000100));
    pending.push_back(mk(FUNC_MAPPER_WR, 1'b1, MapperRamCtrl, 6'd0, 18'd5, 22'h000100));
    pending.push_back(mk(FUNC_MAPPER_WR, 1'b0, 3'd7, 6'd63, 18'd0, 22'h3C0001));
    pending.push_back(mk(FUNC_MAPPER_WR, 1'b0, 3'd1, 6'd0, 18'd0, 22'h080000));
    pending.push_back(mk(FUNC_LOOKUP, 1'b0, 3'd0, 6'd0, 18'd0, 22'h0FFFFF));
    pending.push_back(mk(FUNC_RESET_WRITE, 1'b1, 3'd0, 6'd0, 18'd0, 22'd0));
    pending.push_back(mk(FUNC_REQ_WRITE, 1'b1, 3'd0, 6'd0, 18'h3FFFF, 22'd0));
    pending.push_back(mk(FUNC_ACK_READ, 1'b0, 3'd0, 6'd0, 18'h3FFFF, 22'd0));
    pending.push_back(mk(FUNC_REQ_WRITE, 1'b1, 3'd0, 6'd0, 18'd100, 22'd0));
    pending.push_back(mk(FUNC_ACK_READ, 1'b0, 3'd0, 6'd0, 18'd116, 22'd0));
    pending.push_back(mk(FUNC_ACK_READ, 1'b0, 3'd0, 6'd0, 18'd117, 22'd0));
    pending.push_back(mk(FUNC_REQ_WRITE, 1'b0, 3'd0, 6'd0, 18'd200, 22'd0));
    pending.push_back(mk(FUNC_RESET_WRITE, 1'b0, 3'd0, 6'd0, 18'd300, 22'd0));
    pending.push_back(mk(FUNC_BANK_BIT, 1'b1, 3'd0, 6'd0, 18'd0, 22'd0));
    pending.push_back(mk(FUNC_BANK_BIT, 1'b1, 3'd0, 6'd0, 18'd0, 22'd0));
    pending.push_back(mk(FUNC_BANK_BIT, 1'b0, 3'd0, 6'd0, 18'd0, 22'd0));
    pending.push_back(mk(FUNC_BLOCK_RESET, 1'b0, 3'd0, 6'd0, 18'd0, 22'd0));
    pending.push_back(mk(FUNC_BLOCK_RESET, 1'b1, 3'd0, 6'd0, 18'd0, 22'd0));
    pending.push_back(mk(FUNC_LOOKUP, 1'b0, 3'd0, 6'd0, 18'd0, 22'h0007FF));
    pending.push_back(mk(FUNC_LOOKUP, 1'b0, 3'd0, 6'd0, 18'd0, 22'h001801));
    pending.push_back(mk(FuncSpare, 1'b1, 3'd7, 6'd63, 18'h3FFFF, 22'h3FFFFF));

    start_phase(1'b0, 0, 0);
    queue_random(200);
    start_phase(1'b1, 71, 0);
    queue_random(200);
    start_phase(1'b0, 0, 71);
    queue_random(200);
    start_phase(1'b1, 9, 9);
    queue_random(200);

    // back-pressure: long output hold-off, then a sender pause that drains all results in flight
    start_phase(1'b0, 0, 0);
    queue_random(60);
    hold_req = 1'b1;
    do @(posedge clk_i); while (!hold_done);
    hold_req = 1'b0;
    pause_send = 1'b1;
    do @(posedge clk_i); while (in_valid_i || status_due.size() != 0);
    pause_send = 1'b0;
    queue_random(40);

    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
